### hw/rtl/ctt_pkg.sv
// ----------------------------------------------------------------------------
// Turn table package
// Operation and status codes, the member entry held by each cell of the chain
// and the control group that steers a cell.
// ----------------------------------------------------------------------------
`default_nettype none

package ctt_pkg;

    localparam int IdWidth    = 16;
    localparam int ScoreWidth = 32;
    localparam int PosWidth   = 5;

    typedef enum logic [1:0] {
        OP_APPEND  = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_WALK    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [IdWidth-1:0]           id;
        logic signed [ScoreWidth-1:0] score;
        logic                         turn;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic take_head;
        logic load;
        logic set_turn;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/ctt_if.sv
// ----------------------------------------------------------------------------
// Turn table channels
// Valid/ready channels for the request and for the result of the turn table.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctt_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [15:0]        member_id;
    logic signed [31:0] member_score;

    modport source (output valid, output op, output member_id, output member_score,
                    input ready);
    modport sink (input valid, input op, input member_id, input member_score,
                  output ready);
endinterface

interface ctt_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [15:0]        out_id;
    logic signed [31:0] out_score;
    logic [4:0]         position;
    logic [4:0]         member_total;
    logic               last;

    modport source (output valid, output status, output out_id, output out_score,
                    output position, output member_total, output last, input ready);
    modport sink (input valid, input status, input out_id, input out_score,
                  input position, input member_total, input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/ctt_cell.sv
// ----------------------------------------------------------------------------
// Turn table cell
// One place of the member chain. It loads a new member, takes its
// neighbour's entry or the recirculated head when the chain rotates, and can
// be handed the turn mark.
// ----------------------------------------------------------------------------
`default_nettype none

module ctt_cell (
    input  wire logic              clk,
    input  wire ctt_pkg::cell_ctrl_t ctrl,
    input  wire ctt_pkg::entry_t   nb,
    input  wire ctt_pkg::entry_t   hd,
    input  wire ctt_pkg::entry_t   ld,
    output ctt_pkg::entry_t        q
);
    import ctt_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.load)
        begin
            entry_next = ld;
        end
        else if (ctrl.shift)
        begin
            entry_next = ctrl.take_head ? hd : nb;
        end
        else if (ctrl.set_turn)
        begin
            entry_next.turn = 1'b1;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

`default_nettype wire

### hw/rtl/circular_turn_table.sv
// ----------------------------------------------------------------------------
// Circular turn table
// Ordered ring of members with append, remove by id, turn advance and walk.
// ----------------------------------------------------------------------------
// The members sit in ring order in a chain of cells, the head in the first
// cell, and the member holding the turn carries a mark. Append and any
// request on an empty ring are answered straight from the idle state. Remove
// and advance rotate the whole ring once through the chain, one member per
// cycle, and then give their result from a finish state. Walk gives one
// result per member, one per cycle while the result side takes them. A new
// request is taken once the previous one is finished and its last result has
// left the output register.
`default_nettype none

module circular_turn_table #(
    parameter int DEPTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ctt_req_if.sink   req,
    ctt_rsp_if.source rsp
);
    import ctt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_STEP   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic [CW-1:0] live_reg, live_next;
    logic [CW-1:0] k_reg, k_next;
    logic pass_reg, pass_next;
    logic found_reg, found_next;
    op_t op_reg, op_next;
    logic [IdWidth-1:0] key_reg, key_next;
    logic [IdWidth-1:0] rpt_id_reg, rpt_id_next;
    logic signed [ScoreWidth-1:0] rpt_score_reg, rpt_score_next;

    logic rsp_valid_reg, rsp_valid_next;
    status_t rsp_status_reg, rsp_status_next;
    logic [IdWidth-1:0] rsp_id_reg, rsp_id_next;
    logic signed [ScoreWidth-1:0] rsp_score_reg, rsp_score_next;
    logic [PosWidth-1:0] rsp_pos_reg, rsp_pos_next;
    logic [PosWidth-1:0] rsp_total_reg, rsp_total_next;
    logic rsp_last_reg, rsp_last_next;

    entry_t cell_q [DEPTH];
    cell_ctrl_t cell_ctrl [DEPTH];
    entry_t h;
    entry_t hd;
    entry_t ld;
    logic drop;
    logic step_en;
    logic load_en;
    logic set_turn_en;
    logic step_last;
    op_t req_op;

    assign h         = cell_q[0];
    assign req_op    = op_t'(req.op);
    assign req.ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign drop      = (op_reg == OP_REMOVE) && !found_reg && (h.id == key_reg);
    assign step_last = (k_reg == occ_reg - CW'(1));

    assign ld.id    = req.member_id;
    assign ld.score = req.member_score;
    assign ld.turn  = (occ_reg == '0);

    always_comb
    begin
        hd = h;
        unique case (op_reg)
            OP_REMOVE:  hd.turn = h.turn | pass_reg;
            OP_ADVANCE: hd.turn = pass_reg;
            default:    hd.turn = h.turn;
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            entry_t nb;

            if (gi == DEPTH - 1)
            begin : g_end
                assign nb = hd;
            end
            else
            begin : g_mid
                assign nb = cell_q[gi+1];
            end

            assign cell_ctrl[gi].shift     = step_en;
            assign cell_ctrl[gi].take_head = step_en && !drop && (live_reg == CW'(gi + 1));
            assign cell_ctrl[gi].load      = load_en && (occ_reg == CW'(gi));
            assign cell_ctrl[gi].set_turn  = set_turn_en && (gi == 0);

            ctt_cell u_cell (
                .clk  (clk),
                .ctrl (cell_ctrl[gi]),
                .nb   (nb),
                .hd   (hd),
                .ld   (ld),
                .q    (cell_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        live_next       = live_reg;
        k_next          = k_reg;
        pass_next       = pass_reg;
        found_next      = found_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        rpt_id_next     = rpt_id_reg;
        rpt_score_next  = rpt_score_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_id_next     = rsp_id_reg;
        rsp_score_next  = rsp_score_reg;
        rsp_pos_next    = rsp_pos_reg;
        rsp_total_next  = rsp_total_reg;
        rsp_last_next   = rsp_last_reg;
        step_en         = 1'b0;
        load_en         = 1'b0;
        set_turn_en     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    rsp_id_next    = '0;
                    rsp_score_next = '0;
                    rsp_pos_next   = '0;
                    rsp_last_next  = 1'b1;
                    if (req_op == OP_APPEND)
                    begin
                        rsp_valid_next = 1'b1;
                        if (occ_reg == CW'(DEPTH))
                        begin
                            rsp_status_next = ST_FULL;
                            rsp_total_next  = PosWidth'(occ_reg);
                        end
                        else
                        begin
                            load_en         = 1'b1;
                            occ_next        = occ_reg + CW'(1);
                            rsp_status_next = ST_OK;
                            rsp_total_next  = PosWidth'(occ_reg + CW'(1));
                        end
                    end
                    else if (occ_reg == '0)
                    begin
                        rsp_valid_next  = 1'b1;
                        rsp_status_next = ST_EMPTY;
                        rsp_total_next  = '0;
                    end
                    else
                    begin
                        op_next    = req_op;
                        key_next   = req.member_id;
                        live_next  = occ_reg;
                        k_next     = '0;
                        pass_next  = 1'b0;
                        found_next = 1'b0;
                        state_next = S_STEP;
                    end
                end
            end
            S_STEP:
            begin
                if (op_reg != OP_WALK || !rsp_valid_reg || rsp.ready)
                begin
                    step_en = 1'b1;
                    k_next  = k_reg + CW'(1);
                    if (drop)
                    begin
                        found_next = 1'b1;
                        live_next  = live_reg - CW'(1);
                        pass_next  = h.turn;
                    end
                    else
                    begin
                        pass_next = (op_reg == OP_ADVANCE) ? h.turn : 1'b0;
                    end
                    if (op_reg == OP_ADVANCE && pass_reg)
                    begin
                        rpt_id_next    = h.id;
                        rpt_score_next = h.score;
                    end
                    if (op_reg == OP_WALK)
                    begin
                        rsp_valid_next  = 1'b1;
                        rsp_status_next = ST_OK;
                        rsp_id_next     = h.id;
                        rsp_score_next  = h.score;
                        rsp_pos_next    = PosWidth'(k_reg + CW'(1));
                        rsp_total_next  = PosWidth'(occ_reg);
                        rsp_last_next   = step_last;
                    end
                    if (step_last)
                    begin
                        state_next = (op_reg == OP_WALK) ? S_IDLE : S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                set_turn_en    = pass_reg;
                rsp_valid_next = 1'b1;
                rsp_pos_next   = '0;
                rsp_last_next  = 1'b1;
                if (op_reg == OP_REMOVE)
                begin
                    occ_next        = live_reg;
                    rsp_status_next = found_reg ? ST_OK : ST_NOT_FOUND;
                    rsp_id_next     = '0;
                    rsp_score_next  = '0;
                    rsp_total_next  = PosWidth'(live_reg);
                end
                else
                begin
                    rsp_status_next = ST_OK;
                    rsp_id_next     = pass_reg ? h.id : rpt_id_reg;
                    rsp_score_next  = pass_reg ? h.score : rpt_score_reg;
                    rsp_total_next  = PosWidth'(occ_reg);
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            live_reg      <= '0;
            k_reg         <= '0;
            pass_reg      <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            live_reg      <= live_next;
            k_reg         <= k_next;
            pass_reg      <= pass_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        rpt_id_reg     <= rpt_id_next;
        rpt_score_reg  <= rpt_score_next;
        rsp_status_reg <= rsp_status_next;
        rsp_id_reg     <= rsp_id_next;
        rsp_score_reg  <= rsp_score_next;
        rsp_pos_reg    <= rsp_pos_next;
        rsp_total_reg  <= rsp_total_next;
        rsp_last_reg   <= rsp_last_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.out_id       = rsp_id_reg;
    assign rsp.out_score    = rsp_score_reg;
    assign rsp.position     = rsp_pos_reg;
    assign rsp.member_total = rsp_total_reg;
    assign rsp.last         = rsp_last_reg;

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(DEPTH))
        else $error("member count beyond the ring depth");

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) |-> (live_reg <= occ_reg) && (k_reg < occ_reg))
        else $error("rotation count out of step with the ring");

    a_finish_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |=> rsp_valid_reg && rsp_last_reg)
        else $error("finished request gave no final result");
`endif

endmodule

`default_nettype wire
